// ===== rtl/line_edit_buffer_assert.svh =====
// Assertion macros used by the line editor RTL.
`ifndef LINE_EDIT_BUFFER_ASSERT_SVH
`define LINE_EDIT_BUFFER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LEB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lebuf_pkg.sv =====
// Shared constants, key codes and result type of the line editor.
`timescale 1ns / 1ps
`default_nettype none

package lebuf_pkg;

  // line store geometry
  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 6;

  // most characters the store can hold, as a count value
  localparam logic [CNT_W-1:0] LIM_CAP = CNT_W'((LINE_DEPTH < 63) ? LINE_DEPTH : 63);

  // limit register reset
  localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd19;

  // plain key codes
  localparam logic [CHAR_W-1:0] KEY_CTRL_C   = 8'd3;
  localparam logic [CHAR_W-1:0] KEY_BS       = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_ENTER    = 8'd13;
  localparam logic [CHAR_W-1:0] KEY_EXT      = 8'd224;
  localparam logic [CHAR_W-1:0] KEY_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] KEY_PRINT_HI = 8'd254;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

  // extended key codes (after the prefix)
  localparam logic [CHAR_W-1:0] XKEY_DEL   = 8'd83;
  localparam logic [CHAR_W-1:0] XKEY_LEFT  = 8'd75;
  localparam logic [CHAR_W-1:0] XKEY_RIGHT = 8'd77;
  localparam logic [CHAR_W-1:0] XKEY_WLEFT = 8'd115;
  localparam logic [CHAR_W-1:0] XKEY_WRGT  = 8'd116;

  // one result item
  typedef struct packed {
    logic [CHAR_W-1:0] line_char;
    logic              is_line_char;
    logic              line_done;
    logic [CNT_W-1:0]  line_length;
    logic [CNT_W-1:0]  cur_col;
    logic              accepted;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/lebuf_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lebuf_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lebuf_ctrl.sv =====
// Edit sequencer: key decode, shift loops, word scans and line readout.
`timescale 1ns / 1ps
`default_nettype none

`include "line_edit_buffer_assert.svh"

module lebuf_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [lebuf_pkg::CNT_W-1:0] cfg_data,
  input  wire logic                        key_valid,
  output logic                             key_ready,
  input  wire logic [lebuf_pkg::CHAR_W-1:0] key_code,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output lebuf_pkg::res_t                  res
);

  localparam int AW = lebuf_pkg::ADDR_W;
  localparam int CW = lebuf_pkg::CNT_W;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_INS_SHIFT = 9'b000000010,
    S_INS_PUT   = 9'b000000100,
    S_DEL_SHIFT = 9'b000001000,
    S_WLEFT     = 9'b000010000,
    S_WRIGHT    = 9'b000100000,
    S_ENT_RD    = 9'b001000000,
    S_ENT_OUT   = 9'b010000000,
    S_STATUS    = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]                   count, count_next;
  logic [CW-1:0]                   cursor, cursor_next;
  logic                            ext_pend, ext_pend_next;
  logic [CW-1:0]                   line_limit;
  logic [CW-1:0]                   idx, idx_next;
  logic [CW-1:0]                   chk_addr, chk_addr_next;
  logic                            chk_pend, chk_pend_next;
  logic                            wb_pend, wb_pend_next;
  logic [AW-1:0]                   wb_addr, wb_addr_next;
  logic [lebuf_pkg::CHAR_W-1:0]    key_q, key_q_next;
  logic                            acc, acc_next;
  logic                            done_q, done_q_next;

  logic [CW-1:0]                   lim;
  logic                            key_fire;
  logic                            ent_last;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [lebuf_pkg::CHAR_W-1:0]    ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [lebuf_pkg::CHAR_W-1:0]    ram_rdata;

  // line store
  lebuf_ram #(
    .DEPTH(lebuf_pkg::LINE_DEPTH),
    .WIDTH(lebuf_pkg::CHAR_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign key_ready = (state == S_IDLE);
  assign key_fire  = key_valid && key_ready;
  assign lim       = (line_limit < lebuf_pkg::LIM_CAP) ? line_limit : lebuf_pkg::LIM_CAP;
  assign ent_last  = ((idx + 6'd1) == count);

  // write port: pending shift write-back, or the new character
  always_comb begin
    ram_we    = wb_pend || (state == S_INS_PUT);
    ram_waddr = (state == S_INS_PUT) ? cursor[AW-1:0] : wb_addr;
    ram_wdata = (state == S_INS_PUT) ? key_q : ram_rdata;
  end

  // sequencer next state and read port
  always_comb begin
    state_next    = state;
    count_next    = count;
    cursor_next   = cursor;
    ext_pend_next = ext_pend;
    idx_next      = idx;
    chk_addr_next = chk_addr;
    chk_pend_next = chk_pend;
    wb_pend_next  = 1'b0;
    wb_addr_next  = wb_addr;
    key_q_next    = key_q;
    acc_next      = acc;
    done_q_next   = done_q;
    ram_re        = 1'b0;
    ram_raddr     = idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (key_fire) begin
          key_q_next    = key_code;
          acc_next      = 1'b0;
          done_q_next   = 1'b0;
          chk_pend_next = 1'b0;
          state_next    = S_STATUS;
          if (ext_pend) begin
            ext_pend_next = 1'b0;
            unique case (key_code)
              lebuf_pkg::XKEY_DEL: begin
                if (cursor < count) begin
                  idx_next   = cursor + 6'd1;
                  acc_next   = 1'b1;
                  state_next = S_DEL_SHIFT;
                end
              end
              lebuf_pkg::XKEY_LEFT: begin
                if (cursor != '0) begin
                  cursor_next = cursor - 6'd1;
                  acc_next    = 1'b1;
                end
              end
              lebuf_pkg::XKEY_RIGHT: begin
                if (cursor < count) begin
                  cursor_next = cursor + 6'd1;
                  acc_next    = 1'b1;
                end
              end
              lebuf_pkg::XKEY_WLEFT: begin
                if (cursor == 6'd1) begin
                  cursor_next = '0;
                  acc_next    = 1'b1;
                end else if (cursor != '0) begin
                  idx_next   = cursor - 6'd2;
                  acc_next   = 1'b1;
                  state_next = S_WLEFT;
                end
              end
              lebuf_pkg::XKEY_WRGT: begin
                if ((cursor + 6'd1) == count) begin
                  cursor_next = count;
                  acc_next    = 1'b1;
                end else if (cursor < count) begin
                  idx_next   = cursor + 6'd1;
                  acc_next   = 1'b1;
                  state_next = S_WRIGHT;
                end
              end
              default: begin
              end
            endcase
          end else begin
            unique case (key_code)
              lebuf_pkg::KEY_EXT: begin
                ext_pend_next = 1'b1;
              end
              lebuf_pkg::KEY_CTRL_C: begin
                acc_next    = (count != '0) || (cursor != '0);
                count_next  = '0;
                cursor_next = '0;
              end
              lebuf_pkg::KEY_BS: begin
                if (cursor != '0) begin
                  cursor_next = cursor - 6'd1;
                  idx_next    = cursor;
                  acc_next    = 1'b1;
                  state_next  = S_DEL_SHIFT;
                end
              end
              lebuf_pkg::KEY_ENTER: begin
                acc_next = 1'b1;
                if (count == '0) begin
                  done_q_next = 1'b1;
                end else begin
                  idx_next   = '0;
                  state_next = S_ENT_RD;
                end
              end
              default: begin
                if (key_code >= lebuf_pkg::KEY_PRINT_LO &&
                    key_code <= lebuf_pkg::KEY_PRINT_HI && count < lim) begin
                  idx_next   = count;
                  acc_next   = 1'b1;
                  state_next = S_INS_SHIFT;
                end
              end
            endcase
          end
        end
      end

      // move entries up one place, from the end down to the cursor
      S_INS_SHIFT: begin
        if (idx > cursor) begin
          ram_re       = 1'b1;
          ram_raddr    = idx[AW-1:0] - 1'b1;
          wb_pend_next = 1'b1;
          wb_addr_next = idx[AW-1:0];
          idx_next     = idx - 6'd1;
        end else begin
          state_next = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        count_next  = count + 6'd1;
        cursor_next = cursor + 6'd1;
        state_next  = S_STATUS;
      end

      // move entries down one place, from the gap up to the end
      S_DEL_SHIFT: begin
        if (idx < count) begin
          ram_re       = 1'b1;
          ram_raddr    = idx[AW-1:0];
          wb_pend_next = 1'b1;
          wb_addr_next = idx[AW-1:0] - 1'b1;
          idx_next     = idx + 6'd1;
        end else begin
          count_next = count - 6'd1;
          state_next = S_STATUS;
        end
      end

      // scan down for a space before the new cursor
      S_WLEFT: begin
        if (chk_pend && ram_rdata == lebuf_pkg::CHAR_SPACE) begin
          cursor_next = chk_addr + 6'd1;
          state_next  = S_STATUS;
        end else if (chk_pend && chk_addr == '0) begin
          cursor_next = '0;
          state_next  = S_STATUS;
        end else begin
          ram_re        = 1'b1;
          ram_raddr     = idx[AW-1:0];
          chk_addr_next = idx;
          chk_pend_next = 1'b1;
          idx_next      = idx - 6'd1;
        end
      end

      // scan up for a space under the new cursor
      S_WRIGHT: begin
        if (chk_pend && ram_rdata == lebuf_pkg::CHAR_SPACE) begin
          cursor_next = chk_addr;
          state_next  = S_STATUS;
        end else if (chk_pend && (chk_addr + 6'd1) == count) begin
          cursor_next = count;
          state_next  = S_STATUS;
        end else begin
          ram_re        = 1'b1;
          ram_raddr     = idx[AW-1:0];
          chk_addr_next = idx;
          chk_pend_next = 1'b1;
          idx_next      = idx + 6'd1;
        end
      end

      // line readout, one character per result
      S_ENT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx[AW-1:0];
        state_next = S_ENT_OUT;
      end

      S_ENT_OUT: begin
        if (res_ready) begin
          if (ent_last) begin
            count_next  = '0;
            cursor_next = '0;
            state_next  = S_IDLE;
          end else begin
            idx_next   = idx + 6'd1;
            state_next = S_ENT_RD;
          end
        end
      end

      S_STATUS: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result item
  always_comb begin
    res_valid        = (state == S_STATUS) || (state == S_ENT_OUT);
    res.line_char    = (state == S_ENT_OUT) ? ram_rdata : '0;
    res.is_line_char = (state == S_ENT_OUT);
    res.line_done    = (state == S_ENT_OUT) || done_q;
    res.line_length  = ((state == S_ENT_OUT) || done_q) ? '0 : count;
    res.cur_col      = ((state == S_ENT_OUT) || done_q) ? '0 : cursor;
    res.accepted     = (state == S_ENT_OUT) ? 1'b1 : acc;
    res.last         = (state == S_ENT_OUT) ? ent_last : 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cursor   <= '0;
      ext_pend <= 1'b0;
      chk_pend <= 1'b0;
      wb_pend  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cursor   <= cursor_next;
      ext_pend <= ext_pend_next;
      chk_pend <= chk_pend_next;
      wb_pend  <= wb_pend_next;
      done_q   <= done_q_next;
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= lebuf_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit <= cfg_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    chk_addr <= chk_addr_next;
    wb_addr  <= wb_addr_next;
    key_q    <= key_q_next;
    acc      <= acc_next;
  end

  // checks
  `LEB_ASSERT_NOW(a_cursor_in_line, state == S_IDLE, cursor <= count,
    "cursor beyond end of line")
  `LEB_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
    "store read and written at the same entry")
  `LEB_ASSERT_NEXT(a_insert_grows, state == S_INS_PUT,
    state == S_STATUS && count == $past(count) + 6'd1,
    "insert did not grow the line by one")
  `LEB_ASSERT_NEXT(a_enter_clears, state == S_ENT_OUT && res_ready && ent_last,
    state == S_IDLE && count == '0 && cursor == '0,
    "line not cleared after readout")

endmodule

`default_nettype wire

// ===== rtl/line_edit_buffer.sv =====
// Line editor top level: key stream in, status and line stream out.
// A status item goes through the sequencer state and the output register to m_axis;
//   insert shifts each character after the cursor up and then writes the new one,
//   delete shifts the tail down, word moves scan the line and Enter reads it out one
//   character per result. A new key is taken only while the sequencer is idle.
// Reset empties the line, clears the prefix flag and sets the limit to 19.
`timescale 1ns / 1ps
`default_nettype none

module line_edit_buffer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_data,       // line_limit
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] key_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] line_char, [13:8] line_length,
                                           // [19:14] cur_col, [20] accepted, rest 0
  output logic [7:0]       m_axis_tuser,   // [0] is_line_char, [1] line_done, rest 0
  output logic             m_axis_tlast    // last
);

  logic            res_valid;
  logic            res_ready;
  lebuf_pkg::res_t res;

  logic            out_valid;
  lebuf_pkg::res_t out_res;

  lebuf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .key_valid(s_axis_tvalid),
    .key_ready(s_axis_tready),
    .key_code (s_axis_tdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register, refilled in the cycle it empties
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  // stream packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.accepted, out_res.cur_col,
                          out_res.line_length, out_res.line_char};
  assign m_axis_tuser  = {6'b000000, out_res.line_done, out_res.is_line_char};
  assign m_axis_tlast  = out_res.last;

endmodule

`default_nettype wire
